// ===== rtl/core/cage_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cage_pkg
// shared types, byte codes and glyph tables of the cell to ansi glyph encoder
// ---------------------------------------------------------------------------
package cage_pkg;

    localparam int QueueDepth = 4;
    localparam int NumSlots   = 31;

    localparam logic [7:0] ByteEsc    = 8'h1B;
    localparam logic [7:0] ByteLbrk   = 8'h5B;
    localparam logic [7:0] ByteH      = 8'h48;
    localparam logic [7:0] ByteSpace  = 8'h20;
    localparam logic [7:0] ByteThree  = 8'h33;
    localparam logic [7:0] ByteEight  = 8'h38;
    localparam logic [7:0] ByteTwo    = 8'h32;
    localparam logic [7:0] ByteZero   = 8'h30;
    localparam logic [7:0] ByteSemi   = 8'h3B;
    localparam logic [7:0] ByteM      = 8'h6D;
    localparam logic [7:0] ByteNl     = 8'h0A;
    localparam logic [7:0] ByteUtf3   = 8'hE0;
    localparam logic [7:0] ByteUtfCnt = 8'h80;
    localparam logic [15:0] BrailleBase = 16'h2800;

    typedef struct packed {
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
        logic       ge100;
        logic       ge10;
    } cage_dec_t;

    typedef struct packed {
        logic       home;
        logic       blank;
        logic       esc;
        cage_dec_t  red_dec;
        cage_dec_t  green_dec;
        cage_dec_t  blue_dec;
        logic [15:0] glyph_cp;
        logic       row_end;
        logic       frame_end;
    } cage_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } cage_q_status_t;

    function automatic cage_dec_t to_dec(input logic [7:0] v);
        cage_dec_t  d;
        logic [7:0] rem;
        d.ge100 = (v >= 8'd100);
        d.ge10  = (v >= 8'd10);
        if (v >= 8'd200) begin
            d.hund = 4'd2;
            rem    = v - 8'd200;
        end else if (v >= 8'd100) begin
            d.hund = 4'd1;
            rem    = v - 8'd100;
        end else begin
            d.hund = 4'd0;
            rem    = v;
        end
        d.tens = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (rem >= 8'(i * 10)) d.tens = 4'(i);
        end
        d.ones = 4'(rem - (8'(d.tens) * 8'd10));
        return d;
    endfunction

    function automatic logic [15:0] quad_cp(input logic [3:0] m);
        logic [15:0] cp;
        case (m)
            4'd0:    cp = 16'h0020;
            4'd1:    cp = 16'h2598;
            4'd2:    cp = 16'h259D;
            4'd3:    cp = 16'h2580;
            4'd4:    cp = 16'h2596;
            4'd5:    cp = 16'h258C;
            4'd6:    cp = 16'h259E;
            4'd7:    cp = 16'h259B;
            4'd8:    cp = 16'h2597;
            4'd9:    cp = 16'h259A;
            4'd10:   cp = 16'h2590;
            4'd11:   cp = 16'h259C;
            4'd12:   cp = 16'h2584;
            4'd13:   cp = 16'h2599;
            4'd14:   cp = 16'h259F;
            default: cp = 16'h2588;
        endcase
        return cp;
    endfunction

    // mask bits 0..7 are braille dots 1,4,2,5,3,6,7,8
    function automatic logic [15:0] braille_cp(input logic [7:0] m);
        logic [7:0] dots;
        dots = {m[7], m[6], m[5], m[3], m[1], m[4], m[2], m[0]};
        return BrailleBase | {8'd0, dots};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cage_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cage_front
// accepts cells, tracks the color state and builds one command per cell
// ---------------------------------------------------------------------------
module cage_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [31:0]         s_tdata,   // cell_mask, red, green, blue
    input  wire logic                s_tlast,   // row_end
    input  wire logic [1:0]          s_tuser,   // frame_start, frame_end
    input  wire cage_pkg::cage_q_status_t q_status,
    output logic                     push,
    output cage_pkg::cage_cmd_t      push_cmd
);

    logic        glyph_mode_reg, glyph_mode_next;
    logic [23:0] last_colour_reg, last_colour_next;
    logic        colour_known_reg, colour_known_next;

    logic [7:0]  cell_mask, red, green, blue, used;
    logic [23:0] colour;
    logic        row_end, frame_start, frame_end;
    logic        known_now, blank, esc;

    assign cell_mask   = s_tdata[7:0];
    assign red         = s_tdata[15:8];
    assign green       = s_tdata[23:16];
    assign blue        = s_tdata[31:24];
    assign row_end     = s_tlast;
    assign frame_start = s_tuser[0];
    assign frame_end   = s_tuser[1];

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_status.full;
    assign push      = s_tvalid && s_tready;

    assign used      = glyph_mode_reg ? cell_mask : {4'd0, cell_mask[3:0]};
    assign colour    = {red, green, blue};
    assign blank     = (used == 8'd0);
    assign known_now = colour_known_reg && !frame_start;
    assign esc       = !blank && (!known_now || (colour != last_colour_reg));

    always_comb begin
        push_cmd.home      = frame_start;
        push_cmd.blank     = blank;
        push_cmd.esc       = esc;
        push_cmd.red_dec   = cage_pkg::to_dec(red);
        push_cmd.green_dec = cage_pkg::to_dec(green);
        push_cmd.blue_dec  = cage_pkg::to_dec(blue);
        push_cmd.glyph_cp  = glyph_mode_reg ? cage_pkg::braille_cp(used)
                                            : cage_pkg::quad_cp(used[3:0]);
        push_cmd.row_end   = row_end;
        push_cmd.frame_end = frame_end;
    end

    always_comb begin
        glyph_mode_next   = glyph_mode_reg;
        last_colour_next  = last_colour_reg;
        colour_known_next = colour_known_reg;
        if (cfg_valid && cfg_ready) glyph_mode_next = cfg_data;
        if (push) begin
            if (esc) last_colour_next = colour;
            if (frame_end) begin
                colour_known_next = 1'b0;
            end else if (blank) begin
                colour_known_next = known_now;
            end else begin
                colour_known_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_mode_reg   <= 1'b0;
            last_colour_reg  <= 24'd0;
            colour_known_reg <= 1'b0;
        end else begin
            glyph_mode_reg   <= glyph_mode_next;
            last_colour_reg  <= last_colour_next;
            colour_known_reg <= colour_known_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/cage_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cage_queue
// short command queue between front and back
// ---------------------------------------------------------------------------
module cage_queue #(
    parameter int DEPTH = cage_pkg::QueueDepth
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire cage_pkg::cage_cmd_t push_cmd,
    input  wire logic                pop,
    output cage_pkg::cage_cmd_t      head_cmd,
    output cage_pkg::cage_q_status_t status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    cage_pkg::cage_cmd_t store_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CntW'(DEPTH));
    assign head_cmd     = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop) count_next = count_reg + CntW'(1);
        if (pop && !push) count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) store_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

// ===== rtl/core/cage_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cage_back
// walks the byte slots of the head command, one byte per cycle while m_tready allows
// ---------------------------------------------------------------------------
module cage_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cage_pkg::cage_cmd_t head_cmd,
    input  wire logic                head_valid,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,   // out_byte
    output logic                     m_tlast    // last_of_cell
);

    localparam int N     = cage_pkg::NumSlots;
    localparam int SlotW = $clog2(N);

    localparam int SlHome  = 0;
    localparam int SlSpace = 3;
    localparam int SlPre   = 4;
    localparam int SlRed   = 11;
    localparam int SlSemiG = 14;
    localparam int SlGreen = 15;
    localparam int SlSemiB = 18;
    localparam int SlBlue  = 19;
    localparam int SlM     = 22;
    localparam int SlGlyph = 23;
    localparam int SlNl    = 26;
    localparam int SlRst   = 27;

    logic [7:0]       slot_byte [N];
    logic [N-1:0]     slot_en, masked, rest;
    logic [SlotW-1:0] first_idx;
    logic             is_last, advance;

    logic [SlotW-1:0] pos_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;

    function automatic logic [7:0] digit(input logic [3:0] d);
        return cage_pkg::ByteZero | {4'd0, d};
    endfunction

    always_comb begin
        slot_byte[SlHome]      = cage_pkg::ByteEsc;
        slot_byte[SlHome + 1]  = cage_pkg::ByteLbrk;
        slot_byte[SlHome + 2]  = cage_pkg::ByteH;
        slot_byte[SlSpace]     = cage_pkg::ByteSpace;
        slot_byte[SlPre]       = cage_pkg::ByteEsc;
        slot_byte[SlPre + 1]   = cage_pkg::ByteLbrk;
        slot_byte[SlPre + 2]   = cage_pkg::ByteThree;
        slot_byte[SlPre + 3]   = cage_pkg::ByteEight;
        slot_byte[SlPre + 4]   = cage_pkg::ByteSemi;
        slot_byte[SlPre + 5]   = cage_pkg::ByteTwo;
        slot_byte[SlPre + 6]   = cage_pkg::ByteSemi;
        slot_byte[SlRed]       = digit(head_cmd.red_dec.hund);
        slot_byte[SlRed + 1]   = digit(head_cmd.red_dec.tens);
        slot_byte[SlRed + 2]   = digit(head_cmd.red_dec.ones);
        slot_byte[SlSemiG]     = cage_pkg::ByteSemi;
        slot_byte[SlGreen]     = digit(head_cmd.green_dec.hund);
        slot_byte[SlGreen + 1] = digit(head_cmd.green_dec.tens);
        slot_byte[SlGreen + 2] = digit(head_cmd.green_dec.ones);
        slot_byte[SlSemiB]     = cage_pkg::ByteSemi;
        slot_byte[SlBlue]      = digit(head_cmd.blue_dec.hund);
        slot_byte[SlBlue + 1]  = digit(head_cmd.blue_dec.tens);
        slot_byte[SlBlue + 2]  = digit(head_cmd.blue_dec.ones);
        slot_byte[SlM]         = cage_pkg::ByteM;
        slot_byte[SlGlyph]     = cage_pkg::ByteUtf3 | {4'd0, head_cmd.glyph_cp[15:12]};
        slot_byte[SlGlyph + 1] = cage_pkg::ByteUtfCnt | {2'd0, head_cmd.glyph_cp[11:6]};
        slot_byte[SlGlyph + 2] = cage_pkg::ByteUtfCnt | {2'd0, head_cmd.glyph_cp[5:0]};
        slot_byte[SlNl]        = cage_pkg::ByteNl;
        slot_byte[SlRst]       = cage_pkg::ByteEsc;
        slot_byte[SlRst + 1]   = cage_pkg::ByteLbrk;
        slot_byte[SlRst + 2]   = cage_pkg::ByteZero;
        slot_byte[SlRst + 3]   = cage_pkg::ByteM;
    end

    always_comb begin
        slot_en                   = '0;
        slot_en[SlHome +: 3]      = {3{head_cmd.home}};
        slot_en[SlSpace]          = head_cmd.blank;
        slot_en[SlPre +: 7]       = {7{head_cmd.esc}};
        slot_en[SlRed]            = head_cmd.esc && head_cmd.red_dec.ge100;
        slot_en[SlRed + 1]        = head_cmd.esc && head_cmd.red_dec.ge10;
        slot_en[SlRed + 2]        = head_cmd.esc;
        slot_en[SlSemiG]          = head_cmd.esc;
        slot_en[SlGreen]          = head_cmd.esc && head_cmd.green_dec.ge100;
        slot_en[SlGreen + 1]      = head_cmd.esc && head_cmd.green_dec.ge10;
        slot_en[SlGreen + 2]      = head_cmd.esc;
        slot_en[SlSemiB]          = head_cmd.esc;
        slot_en[SlBlue]           = head_cmd.esc && head_cmd.blue_dec.ge100;
        slot_en[SlBlue + 1]       = head_cmd.esc && head_cmd.blue_dec.ge10;
        slot_en[SlBlue + 2]       = head_cmd.esc;
        slot_en[SlM]              = head_cmd.esc;
        slot_en[SlGlyph +: 3]     = {3{!head_cmd.blank}};
        slot_en[SlNl]             = head_cmd.row_end;
        slot_en[SlRst +: 4]       = {4{head_cmd.frame_end}};
    end

    // lowest enabled slot at or after the current position
    always_comb begin
        masked    = slot_en & ~((N'(1) << pos_reg) - N'(1));
        first_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (masked[i]) first_idx = SlotW'(i);
        end
        rest    = masked & ~(N'(1) << first_idx);
        is_last = (rest == '0);
    end

    assign advance  = head_valid && (!valid_reg || m_tready);
    assign pop      = advance && is_last;
    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (advance) begin
            valid_reg <= 1'b1;
            pos_reg   <= is_last ? '0 : first_idx + SlotW'(1);
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_reg <= slot_byte[first_idx];
            last_reg <= is_last;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/cell_to_ansi_glyph_encoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cell_to_ansi_glyph_encoder_core
// encodes screen cells into an ansi truecolor terminal byte stream
// ---------------------------------------------------------------------------
// path: first byte of a cell reaches m_tvalid through the queue store and
// the output byte register, when the queue and output register are empty
// throughput: one byte per cycle at the output register while m_tready is
// high, and a cell gives 1 to 30 bytes; cells enter one per cycle while
// the command queue has room
// reset: synchronous aresetn clears queue, output, mode and color state
module cell_to_ansi_glyph_encoder_core #(
    parameter int QUEUE_DEPTH = cage_pkg::QueueDepth
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,    // glyph_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // cell_mask, red, green, blue
    input  wire logic        s_tlast,     // row_end
    input  wire logic [1:0]  s_tuser,     // frame_start, frame_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // out_byte
    output logic             m_tlast      // last_of_cell
);

    cage_pkg::cage_cmd_t      push_cmd, head_cmd;
    cage_pkg::cage_q_status_t q_status;
    logic                     push, pop;

    cage_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    cage_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    cage_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_cmd   (head_cmd),
        .head_valid (!q_status.empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_back_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_status.empty && !m_tvalid) |=> m_tvalid)
        else $error("back idle with queued work");

    a_no_phantom_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.empty && !m_tvalid) |=> !m_tvalid)
        else $error("output byte without queued command");

    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_tvalid && m_tlast))
        else $error("command popped without final byte");

endmodule
`default_nettype wire
